>>> design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int KIND_W  = 3;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK       = 3'd4
    } kind_t;

    typedef struct packed {
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] back_value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               overflow;
        logic               underflow;
    } res_t;

endpackage

>>> design/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue in a circular buffer with a programmable capacity.
//
//   channel  handshake             payload
//   -------  --------------------  -------------------------------------------
//   in       in_valid / in_ready   kind, value
//   out      out_valid / out_ready front_value, back_value, count, is_empty,
//                                  overflow, underflow
//   cfg      cfg_valid / cfg_ready capacity
//
// One item per cycle while out is not stalled; each result passes through the
// registered storage read and result stage, then the output queue.
// A capacity write empties the deque; cfg_ready is always high.
// Reset empties the deque and sets capacity to 16; no clearing pass.
// Stalls on out drop in_ready once the two-entry output queue would fill.
// ----------------------------------------------------------------------------
module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] front_value,
    output logic [VALUE_W-1:0] back_value,
    output logic [COUNT_W-1:0] count,
    output logic               is_empty,
    output logic               overflow,
    output logic               underflow,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   capacity
);

    logic acc;
    logic s_valid;
    res_t s_res;
    res_t out_res;
    logic space;

    assign cfg_ready = 1'b1;
    assign in_ready  = space;
    assign acc       = in_valid && in_ready;

    cdq_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .kind    (kind),
        .value   (value),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_cap (capacity),
        .s_valid (s_valid),
        .s_res   (s_res)
    );

    cdq_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_valid),
        .push_res  (s_res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign front_value = out_res.front_value;
    assign back_value  = out_res.back_value;
    assign count       = out_res.count;
    assign is_empty    = out_res.is_empty;
    assign overflow    = out_res.overflow;
    assign underflow   = out_res.underflow;

endmodule

>>> design/cdq_core.sv
// ----------------------------------------------------------------------------
// cdq_core
// Deque state, storage memory and result stage. One operation per cycle.
// ----------------------------------------------------------------------------
module cdq_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               acc,
    input  logic [KIND_W-1:0]  kind,
    input  logic [VALUE_W-1:0] value,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_cap,
    output logic               s_valid,
    output res_t               s_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0] cap_reg;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             s_valid_reg;
    logic             ovf_reg, ovf_next;
    logic             unf_reg, unf_next;

    logic [VALUE_W-1:0] rd_front_reg, rd_back_reg, wval_reg;
    logic               byp_front_reg, byp_back_reg;

    logic [EW-1:0] cap_ext, eff_cap, cnt_ext;
    logic [AW-1:0] last_idx;
    logic          full, empty;
    logic          we;
    logic [AW-1:0] wa;

    assign cap_ext  = EW'(cap_reg);
    assign eff_cap  = (cap_ext == '0) ? EW'(1) :
                      (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;
    assign last_idx = AW'(eff_cap - EW'(1));
    assign cnt_ext  = EW'(cnt_reg);
    assign full     = cnt_ext >= eff_cap;
    assign empty    = (cnt_reg == '0);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        ovf_next  = 1'b0;
        unf_next  = 1'b0;
        we        = 1'b0;
        wa        = '0;
        if (acc)
        begin
            case (kind_t'(kind)) inside
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (empty)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        cnt_next  = CW'(1);
                        we        = 1'b1;
                        wa        = '0;
                    end
                    else if (kind_t'(kind) == KIND_PUSH_FRONT)
                    begin
                        head_next = (head_reg == '0) ? last_idx : head_reg - AW'(1);
                        cnt_next  = cnt_reg + CW'(1);
                        we        = 1'b1;
                        wa        = head_next;
                    end
                    else
                    begin
                        tail_next = (tail_reg == last_idx) ? '0 : tail_reg + AW'(1);
                        cnt_next  = cnt_reg + CW'(1);
                        we        = 1'b1;
                        wa        = tail_next;
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK:
                begin
                    if (empty)
                    begin
                        unf_next = 1'b1;
                    end
                    else if (head_reg == tail_reg)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        cnt_next  = '0;
                    end
                    else if (kind_t'(kind) == KIND_POP_FRONT)
                    begin
                        head_next = (head_reg == last_idx) ? '0 : head_reg + AW'(1);
                        cnt_next  = cnt_reg - CW'(1);
                    end
                    else
                    begin
                        tail_next = (tail_reg == '0) ? last_idx : tail_reg - AW'(1);
                        cnt_next  = cnt_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= '0;
            s_valid_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            unf_reg     <= 1'b0;
        end
        else
        begin
            s_valid_reg <= acc;
            ovf_reg     <= ovf_next;
            unf_reg     <= unf_next;
            if (cfg_we)
            begin
                cap_reg  <= cfg_cap;
                head_reg <= '0;
                tail_reg <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // storage with registered reads at the new ends; same-cycle write is bypassed
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= value;
        end
        rd_front_reg  <= mem[head_next];
        rd_back_reg   <= mem[tail_next];
        byp_front_reg <= we && (wa == head_next);
        byp_back_reg  <= we && (wa == tail_next);
        wval_reg      <= value;
    end

    assign s_valid           = s_valid_reg;
    assign s_res.front_value = empty ? '0 : (byp_front_reg ? wval_reg : rd_front_reg);
    assign s_res.back_value  = empty ? '0 : (byp_back_reg ? wval_reg : rd_back_reg);
    assign s_res.count       = cnt_ext[COUNT_W-1:0];
    assign s_res.is_empty    = empty;
    assign s_res.overflow    = ovf_reg;
    assign s_res.underflow   = unf_reg;

    a_cnt_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= eff_cap)
        else $error("count exceeds capacity");

    a_ovf_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !cfg_we && full &&
         (kind_t'(kind) == KIND_PUSH_FRONT || kind_t'(kind) == KIND_PUSH_BACK))
        |=> (cnt_reg == $past(cnt_reg)) && ovf_reg)
        else $error("refused push changed count");

    a_unf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && unf_reg) |-> empty)
        else $error("underflow on non-empty deque");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (EW'(head_reg) < eff_cap) && (EW'(tail_reg) < eff_cap))
        else $error("index beyond capacity");

endmodule

>>> design/cdq_out_fifo.sv
// ----------------------------------------------------------------------------
// cdq_out_fifo
// Two-entry result queue decoupling the result stage from the output port.
// ----------------------------------------------------------------------------
module cdq_out_fifo
    import cdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic space,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    res_t       ent [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;
    logic [2:0] occ;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_res   = ent[rd_ptr_reg];

    // room for one more item in flight through the result stage
    assign occ   = 3'(cnt_reg) + 3'(push);
    assign space = occ <= (3'(pop) + 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= 2'(3'(cnt_reg) + 3'(push) - 3'(pop));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent[wr_ptr_reg] <= push_res;
        end
    end

endmodule
